// File: rtl/core/lmf_pkg.sv
// Shared constants, codes and types of the LED matrix framebuffer.
package lmf_pkg;

  // Longest driver chain and the byte store that backs it (eight digit rows per driver).
  localparam int MaxDrivers = 8;
  localparam int DigitRows  = 8;
  localparam int StoreDepth = DigitRows * MaxDrivers;
  localparam int AddrW      = $clog2(StoreDepth);
  // Effective chain length, 0 up to MaxDrivers.
  localparam int ChainW     = $clog2(MaxDrivers + 1);

  // Depths of the command queue and of the result queue.
  localparam int OpqDepth   = 2;
  localparam int OutqDepth  = 2;

  // Input command codes.
  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_TOGGLE = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_SHOW   = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  // Result kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // Operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_WRITE,
    OP_TOGGLE,
    OP_READ,
    OP_CLEAR,
    OP_SHOW
  } op_kind_e;

  typedef struct packed {
    op_kind_e         kind;
    logic             in_bounds;
    logic [AddrW-1:0] addr;
    logic [2:0]       bit_sel;
    logic             value;
  } op_t;

  // One result item.
  typedef struct packed {
    logic       result_kind;
    logic       pixel_bit;
    logic [2:0] digit_row;
    logic [2:0] driver_index;
    logic [7:0] frame_byte;
    logic       last_of_run;
  } result_t;

endpackage

// File: rtl/core/lmf_front.sv
// Front end: bounds-checks a pixel coordinate and turns a command into a store operation.
module lmf_front (
  input  logic                       push_i,
  input  logic [2:0]                 command_i,
  input  logic signed [15:0]         x_coord_i,
  input  logic signed [15:0]         y_coord_i,
  input  logic                       pixel_value_i,
  input  logic [3:0]                 grid_columns_i,
  input  logic [3:0]                 grid_rows_i,
  input  logic [lmf_pkg::ChainW-1:0] chain_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output lmf_pkg::op_t               q_op_o
);

  logic [6:0] x_lim;
  logic [6:0] y_lim;
  logic       x_in;
  logic       y_in;
  logic [7:0] row_base;
  logic [8:0] drv;
  logic       drv_in;
  logic [6:0] idx_full;
  logic       in_bounds;
  logic       keep;
  lmf_pkg::op_kind_e kind;

  // Coordinate range check against the grid size in pixels.
  assign x_lim = {grid_columns_i, 3'b000};
  assign y_lim = {grid_rows_i, 3'b000};
  assign x_in  = !x_coord_i[15] && (x_coord_i[14:0] < 15'(x_lim));
  assign y_in  = !y_coord_i[15] && (y_coord_i[14:0] < 15'(y_lim));

  // Driver position in the chain; only the low bits matter once the range check passes.
  assign row_base = 8'(y_coord_i[6:3]) * 8'(grid_columns_i);
  assign drv      = 9'(row_base) + 9'(x_coord_i[6:3]);
  assign drv_in   = drv < 9'(chain_i);

  // Store address, digit-major: digit row times chain length plus driver.
  assign idx_full  = 7'(y_coord_i[2:0]) * 7'(chain_i) + 7'(drv[2:0]);
  assign in_bounds = x_in && y_in && drv_in;

  // Decode the command; pixel updates outside the display are dropped here.
  always_comb begin
    kind = lmf_pkg::OP_WRITE;
    keep = 1'b0;
    unique case (command_i)
      lmf_pkg::CMD_WRITE: begin
        kind = lmf_pkg::OP_WRITE;
        keep = in_bounds;
      end
      lmf_pkg::CMD_TOGGLE: begin
        kind = lmf_pkg::OP_TOGGLE;
        keep = in_bounds;
      end
      lmf_pkg::CMD_READ: begin
        kind = lmf_pkg::OP_READ;
        keep = 1'b1;
      end
      lmf_pkg::CMD_CLEAR: begin
        kind = lmf_pkg::OP_CLEAR;
        keep = 1'b1;
      end
      lmf_pkg::CMD_SHOW: begin
        kind = lmf_pkg::OP_SHOW;
        keep = 1'b1;
      end
      default: begin
        kind = lmf_pkg::OP_WRITE;
        keep = 1'b0;
      end
    endcase
  end

  assign q_push_o         = push_i && !q_full_i && keep;
  assign q_op_o.kind      = kind;
  assign q_op_o.in_bounds = in_bounds;
  assign q_op_o.addr      = idx_full[lmf_pkg::AddrW-1:0];
  assign q_op_o.bit_sel   = x_coord_i[2:0];
  assign q_op_o.value     = pixel_value_i;

endmodule

// File: rtl/core/lmf_opq.sv
// Short queue of decoded operations between the front end and the back end.
module lmf_opq (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  lmf_pkg::op_t op_i,
  output logic         full_o,
  input  logic         pop_i,
  output lmf_pkg::op_t op_o,
  output logic         empty_o
);

  localparam int PtrW = (lmf_pkg::OpqDepth > 1) ? $clog2(lmf_pkg::OpqDepth) : 1;
  localparam int CntW = $clog2(lmf_pkg::OpqDepth + 1);

  lmf_pkg::op_t  ent_q [lmf_pkg::OpqDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = cnt_q == CntW'(lmf_pkg::OpqDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign op_o    = ent_q[rd_ptr_q];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(lmf_pkg::OpqDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(lmf_pkg::OpqDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// File: rtl/core/lmf_back.sv
// Back end: owns the frame store, executes operations and queues the results.
module lmf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [lmf_pkg::ChainW-1:0] chain_i,
  input  logic                       opq_empty_i,
  input  lmf_pkg::op_t               opq_op_i,
  output logic                       opq_pop_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output lmf_pkg::result_t           result_o
);

  localparam int AddrW = lmf_pkg::AddrW;
  localparam int OPtrW = (lmf_pkg::OutqDepth > 1) ? $clog2(lmf_pkg::OutqDepth) : 1;
  localparam int OCntW = $clog2(lmf_pkg::OutqDepth + 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MODIFY = 2'd1;
  localparam logic [1:0] S_ANSWER = 2'd2;
  localparam logic [1:0] S_SHOW   = 2'd3;

  logic [1:0]       state_q, state_d;
  lmf_pkg::op_t     cur_q, cur_d;
  logic [2:0]       d_q, d_d;
  logic [2:0]       r_q, r_d;
  logic [AddrW-1:0] k_q, k_d;

  logic [7:0]            mem_q [lmf_pkg::StoreDepth];
  logic [lmf_pkg::StoreDepth-1:0] valid_q;
  logic [7:0]            rd_data_q;
  logic                  rd_valid_q;
  logic [AddrW-1:0]      rd_addr;
  logic                  wr_en;
  logic [7:0]            wr_data;
  logic                  clear_all;
  logic [7:0]            cur_byte;
  logic [7:0]            bit_mask;
  logic                  r_wrap;
  logic                  show_last;

  lmf_pkg::result_t outq_q [lmf_pkg::OutqDepth];
  logic [OPtrW-1:0] owr_q, owr_d;
  logic [OPtrW-1:0] ord_q, ord_d;
  logic [OCntW-1:0] ocnt_q, ocnt_d;
  logic             out_full;
  logic             out_pop;
  logic             enq;
  lmf_pkg::result_t enq_res;

  // An entry never written since reset or the last clear reads as zero.
  assign cur_byte  = rd_valid_q ? rd_data_q : 8'h00;
  assign bit_mask  = 8'h01 << cur_q.bit_sel;
  assign r_wrap    = (lmf_pkg::ChainW'(r_q) + 1'b1) == chain_i;
  assign show_last = (d_q == 3'(lmf_pkg::DigitRows - 1)) && r_wrap;

  assign out_full = ocnt_q == OCntW'(lmf_pkg::OutqDepth);
  assign empty_o  = ocnt_q == '0;
  assign out_pop  = pop_i && !empty_o;
  assign result_o = outq_q[ord_q];

  // Operation sequencer.
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    d_d       = d_q;
    r_d       = r_q;
    k_d       = k_q;
    rd_addr   = cur_q.addr;
    opq_pop_o = 1'b0;
    wr_en     = 1'b0;
    wr_data   = cur_byte;
    clear_all = 1'b0;
    enq       = 1'b0;
    enq_res   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (!opq_empty_i) begin
          opq_pop_o = 1'b1;
          cur_d     = opq_op_i;
          rd_addr   = opq_op_i.addr;
          unique case (opq_op_i.kind) inside
            lmf_pkg::OP_WRITE, lmf_pkg::OP_TOGGLE: state_d = S_MODIFY;
            lmf_pkg::OP_READ:                      state_d = S_ANSWER;
            lmf_pkg::OP_CLEAR:                     clear_all = 1'b1;
            lmf_pkg::OP_SHOW: begin
              if (chain_i != '0) begin
                rd_addr = '0;
                d_d     = '0;
                r_d     = '0;
                k_d     = '0;
                state_d = S_SHOW;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_MODIFY: begin
        // Second half of the read-modify-write on one store byte.
        wr_en = 1'b1;
        if (cur_q.kind == lmf_pkg::OP_TOGGLE) begin
          wr_data = cur_byte ^ bit_mask;
        end else if (cur_q.value) begin
          wr_data = cur_byte | bit_mask;
        end else begin
          wr_data = cur_byte & ~bit_mask;
        end
        state_d = S_IDLE;
      end
      S_ANSWER: begin
        if (!out_full) begin
          enq                 = 1'b1;
          enq_res.result_kind = lmf_pkg::KIND_PIXEL;
          enq_res.pixel_bit   = cur_q.in_bounds && cur_byte[cur_q.bit_sel];
          enq_res.last_of_run = 1'b1;
          state_d             = S_IDLE;
        end
      end
      S_SHOW: begin
        // One byte per cycle while the result queue has room; the next read is issued as the current byte is queued.
        rd_addr = k_q;
        if (!out_full) begin
          enq                  = 1'b1;
          enq_res.result_kind  = lmf_pkg::KIND_FRAME;
          enq_res.digit_row    = d_q;
          enq_res.driver_index = r_q;
          enq_res.frame_byte   = cur_byte;
          enq_res.last_of_run  = show_last;
          if (show_last) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            rd_addr = k_d;
            if (r_wrap) begin
              r_d = '0;
              d_d = d_q + 1'b1;
            end else begin
              r_d = r_q + 1'b1;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    d_q   <= d_d;
    r_q   <= r_d;
    k_q   <= k_d;
  end

  // Frame store: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cur_q.addr] <= wr_data;
    end
    rd_data_q  <= mem_q[rd_addr];
    rd_valid_q <= valid_q[rd_addr];
  end

  // Per-byte valid bits; reset and clear empty the whole store at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_all) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[cur_q.addr] <= 1'b1;
    end
  end

  // Result queue bookkeeping.
  always_comb begin
    owr_d  = owr_q;
    ord_d  = ord_q;
    ocnt_d = ocnt_q;
    if (enq) begin
      owr_d = (owr_q == OPtrW'(lmf_pkg::OutqDepth - 1)) ? '0 : owr_q + 1'b1;
    end
    if (out_pop) begin
      ord_d = (ord_q == OPtrW'(lmf_pkg::OutqDepth - 1)) ? '0 : ord_q + 1'b1;
    end
    if (enq && !out_pop) begin
      ocnt_d = ocnt_q + 1'b1;
    end else if (out_pop && !enq) begin
      ocnt_d = ocnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      owr_q  <= owr_d;
      ord_q  <= ord_d;
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      outq_q[owr_q] <= enq_res;
    end
  end

endmodule

// File: rtl/core/led_matrix_framebuffer.sv
// Top level of the LED matrix framebuffer: configuration registers and the front/back pipeline.
//
// Commands enter through a queue-style port: an item transfers when push is high and full
// is low. Results leave the same way: the oldest result sits on the result ports while
// empty is low and transfers when pop is high. grid_columns and grid_rows are written
// through cfg_we_i / cfg_idx_i / cfg_data_i; the user must do so only while no command is
// in flight, as the block does not enforce it. The front end decodes and bounds-checks each
// command in the cycle it arrives and places it in a two-entry operation queue. The back end
// executes one operation at a time on a store with one write and one registered read port:
//   write and toggle read the byte, then write it back; clear drops every valid bit;
//   a read answer is queued once the result queue has room;
//   show emits chain*8 bytes at one per cycle while the result queue has room.
// A pixel update holds the back end through its read and its write-back, so the next
// operation starts after the write-back. Reset clears the per-byte valid bits, so the store
// reads as zero at once with no sweep, and restores a 1x1 grid. When the receiver holds
// off pop, the two-entry result queue fills, the back end pauses, the operation queue fills
// and full rises; nothing is dropped.
module led_matrix_framebuffer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [3:0]         cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         command_i,
  input  logic signed [15:0] x_coord_i,
  input  logic signed [15:0] y_coord_i,
  input  logic               pixel_value_i,
  output logic               empty,
  input  logic               pop,
  output logic               result_kind_o,
  output logic               pixel_bit_o,
  output logic [2:0]         digit_row_o,
  output logic [2:0]         driver_index_o,
  output logic [7:0]         frame_byte_o,
  output logic               last_of_run_o
);

  logic [3:0]                 grid_columns_q, grid_columns_d;
  logic [3:0]                 grid_rows_q, grid_rows_d;
  logic [7:0]                 grid_cells;
  logic [lmf_pkg::ChainW-1:0] chain;
  logic                       q_push;
  lmf_pkg::op_t               q_op_in;
  logic                       q_full;
  logic                       q_pop;
  lmf_pkg::op_t               q_op_out;
  logic                       q_empty;
  lmf_pkg::result_t           result;

  // Configuration register writes.
  always_comb begin
    grid_columns_d = grid_columns_q;
    grid_rows_d    = grid_rows_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lmf_pkg::CFG_COLUMNS: grid_columns_d = cfg_data_i;
        lmf_pkg::CFG_ROWS:    grid_rows_d    = cfg_data_i;
        default:              grid_columns_d = grid_columns_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q <= 4'd1;
      grid_rows_q    <= 4'd1;
    end else begin
      grid_columns_q <= grid_columns_d;
      grid_rows_q    <= grid_rows_d;
    end
  end

  // Effective chain length, clamped to the longest supported chain.
  assign grid_cells = 8'(grid_columns_q) * 8'(grid_rows_q);
  assign chain      = (grid_cells > 8'(lmf_pkg::MaxDrivers)) ?
                      lmf_pkg::ChainW'(lmf_pkg::MaxDrivers) :
                      grid_cells[lmf_pkg::ChainW-1:0];

  lmf_front u_front (
    .push_i         (push),
    .command_i      (command_i),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .pixel_value_i  (pixel_value_i),
    .grid_columns_i (grid_columns_q),
    .grid_rows_i    (grid_rows_q),
    .chain_i        (chain),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_op_o         (q_op_in)
  );

  lmf_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (q_op_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .op_o    (q_op_out),
    .empty_o (q_empty)
  );

  lmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chain_i     (chain),
    .opq_empty_i (q_empty),
    .opq_op_i    (q_op_out),
    .opq_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result)
  );

  assign full           = q_full;
  assign result_kind_o  = result.result_kind;
  assign pixel_bit_o    = result.pixel_bit;
  assign digit_row_o    = result.digit_row;
  assign driver_index_o = result.driver_index;
  assign frame_byte_o   = result.frame_byte;
  assign last_of_run_o  = result.last_of_run;

  // A pixel answer is a single result with the frame fields at zero.
  a_pixel_answer_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o == lmf_pkg::KIND_PIXEL) |->
      (last_of_run_o && frame_byte_o == 8'h00 && digit_row_o == 3'd0 &&
       driver_index_o == 3'd0))
    else $error("pixel answer carries frame fields");

  // A frame byte names a driver inside the active chain and has no pixel bit.
  a_frame_in_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o == lmf_pkg::KIND_FRAME) |->
      (!pixel_bit_o && lmf_pkg::ChainW'(driver_index_o) < chain))
    else $error("frame byte outside the active chain");

  // The last frame byte of a show is the last driver of the last digit row.
  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o == lmf_pkg::KIND_FRAME && last_of_run_o) |->
      (digit_row_o == 3'(lmf_pkg::DigitRows - 1) &&
       (lmf_pkg::ChainW'(driver_index_o) + 1'b1) == chain))
    else $error("show run ended early");

endmodule
